// ----- hw/rtl/ldcs_pkg.sv -----
// Package with constants, the font table and shared types of the LCD draw command sequencer.
`timescale 1ns / 1ps
package ldcs_pkg;
    localparam int GlyphCountDefault = 95;
    localparam int FontRows = 95;
    localparam logic [7:0] CMD_COLUMN = 8'h2A;
    localparam logic [7:0] CMD_PAGE = 8'h2B;
    localparam logic [7:0] CMD_WRITE = 8'h2C;
    localparam logic [6:0] FIRST_CODE = 7'd32;
    localparam logic [2:0] LAST_COLUMN = 3'd5;
    localparam logic [2:0] LAST_ROW = 3'd7;

    typedef enum logic [1:0] {
        OP_TICK = 2'd0,
        OP_FILL = 2'd1,
        OP_PIXEL = 2'd2,
        OP_CHAR = 2'd3
    } t_op;

    function automatic logic [7:0] font_column(input logic [6:0] idx, input logic [2:0] col);
        logic [39:0] row;
        begin
            case (idx)
                7'd0: row = 40'h0000000000; 7'd1: row = 40'h00065F0600;
                7'd2: row = 40'h0703000703; 7'd3: row = 40'h247E247E24;
                7'd4: row = 40'h242B6A1200; 7'd5: row = 40'h6313086463;
                7'd6: row = 40'h3649562050; 7'd7: row = 40'h0007030000;
                7'd8: row = 40'h003E410000; 7'd9: row = 40'h00413E0000;
                7'd10: row = 40'h083E1C3E08; 7'd11: row = 40'h08083E0808;
                7'd12: row = 40'h00E0600000; 7'd13: row = 40'h0808080808;
                7'd14: row = 40'h0060600000; 7'd15: row = 40'h2010080402;
                7'd16: row = 40'h3E5149453E; 7'd17: row = 40'h00427F4000;
                7'd18: row = 40'h6251494946; 7'd19: row = 40'h2249494936;
                7'd20: row = 40'h1814127F10; 7'd21: row = 40'h2F49494931;
                7'd22: row = 40'h3C4A494930; 7'd23: row = 40'h0171090503;
                7'd24: row = 40'h3649494936; 7'd25: row = 40'h064949291E;
                7'd26: row = 40'h006C6C0000; 7'd27: row = 40'h00EC6C0000;
                7'd28: row = 40'h0814224100; 7'd29: row = 40'h2424242424;
                7'd30: row = 40'h0041221408; 7'd31: row = 40'h0201590906;
                7'd32: row = 40'h3E415D551E; 7'd33: row = 40'h7E0909097E;
                7'd34: row = 40'h7F49494936; 7'd35: row = 40'h3E41414122;
                7'd36: row = 40'h7F4141413E; 7'd37: row = 40'h7F49494941;
                7'd38: row = 40'h7F09090901; 7'd39: row = 40'h3E4149497A;
                7'd40: row = 40'h7F0808087F; 7'd41: row = 40'h00417F4100;
                7'd42: row = 40'h304040403F; 7'd43: row = 40'h7F08142241;
                7'd44: row = 40'h7F40404040; 7'd45: row = 40'h7F0204027F;
                7'd46: row = 40'h7F0204087F; 7'd47: row = 40'h3E4141413E;
                7'd48: row = 40'h7F09090906; 7'd49: row = 40'h3E4151215E;
                7'd50: row = 40'h7F09091966; 7'd51: row = 40'h2649494932;
                7'd52: row = 40'h01017F0101; 7'd53: row = 40'h3F4040403F;
                7'd54: row = 40'h1F2040201F; 7'd55: row = 40'h3F403C403F;
                7'd56: row = 40'h6314081463; 7'd57: row = 40'h0708700807;
                7'd58: row = 40'h7149454300; 7'd59: row = 40'h007F414100;
                7'd60: row = 40'h0204081020; 7'd61: row = 40'h0041417F00;
                7'd62: row = 40'h0402010204; 7'd63: row = 40'h8080808080;
                7'd64: row = 40'h2040804020; 7'd65: row = 40'h2054545478;
                7'd66: row = 40'h7F44444438; 7'd67: row = 40'h3844444428;
                7'd68: row = 40'h384444447F; 7'd69: row = 40'h3854545418;
                7'd70: row = 40'h087E090900; 7'd71: row = 40'h18A4A4A47C;
                7'd72: row = 40'h7F04047800; 7'd73: row = 40'h00007D0000;
                7'd74: row = 40'h4080847D00; 7'd75: row = 40'h7F10284400;
                7'd76: row = 40'h00007F4000; 7'd77: row = 40'h7C04180478;
                7'd78: row = 40'h7C04047800; 7'd79: row = 40'h3844444438;
                7'd80: row = 40'hFC44444438; 7'd81: row = 40'h38444444FC;
                7'd82: row = 40'h4478440408; 7'd83: row = 40'h0854545420;
                7'd84: row = 40'h043E442400; 7'd85: row = 40'h3C40207C00;
                7'd86: row = 40'h1C2040201C; 7'd87: row = 40'h3C6030603C;
                7'd88: row = 40'h6C10106C00; 7'd89: row = 40'h9CA0603C00;
                7'd90: row = 40'h6454544C00; 7'd91: row = 40'h3366CC6633;
                7'd92: row = 40'h00007F0000; 7'd93: row = 40'hCC663366CC;
                7'd94: row = 40'h0201020100;
                default: row = 40'h0;
            endcase
            case (col)
                3'd0: font_column = row[39:32];
                3'd1: font_column = row[31:24];
                3'd2: font_column = row[23:16];
                3'd3: font_column = row[15:8];
                3'd4: font_column = row[7:0];
                default: font_column = 8'h00;
            endcase
        end
    endfunction
endpackage

// ----- hw/rtl/lcd_draw_command_sequencer.sv -----
// Top level of the LCD draw command sequencer.
`timescale 1ns / 1ps
// Each request is registered at the input; a word that it yields (a rejection, or a step
// of a busy operation on a tick) is then registered in the output register and flagged by o_valid.
// Throughput is one request per cycle while o_stall is low, as the sequencer steps once per request.
// Synchronous active-low reset clears the sequencer state and the output valid.
module lcd_draw_command_sequencer #(
    parameter int GLYPH_COUNT = ldcs_pkg::GlyphCountDefault
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [1:0] i_operation,
    input  logic [7:0] i_fg_color,
    input  logic [7:0] i_bg_color,
    input  logic [7:0] i_x_first,
    input  logic [7:0] i_y_first,
    input  logic [7:0] i_x_second,
    input  logic [7:0] i_y_second,
    input  logic [6:0] i_char_code,
    output logic       o_valid,
    input  logic       i_stall,
    output logic       o_is_data,
    output logic [7:0] o_word_byte,
    output logic       o_last_word,
    output logic       o_rejected
);
    logic       r_in_v;
    logic [1:0] r_op;
    logic [7:0] r_fg, r_bg, r_xa, r_ya, r_xb, r_yb;
    logic [6:0] r_code;

    logic        r_busy, n_busy;
    logic [1:0]  r_aop, n_aop;
    logic [3:0]  r_phase, n_phase;
    logic [2:0]  r_gcol, n_gcol;
    logic [16:0] r_left, n_left;
    logic [7:0]  r_hfg, n_hfg, r_hbg, n_hbg;
    logic [7:0]  r_cl, n_cl, r_ch, n_ch, r_rl, n_rl, r_rh, n_rh;
    logic [6:0]  r_gidx, n_gidx;

    logic       r_ov;
    logic       r_od, r_ol, r_orj;
    logic [7:0] r_ob;
    logic       n_res, n_od, n_ol, n_orj;
    logic [7:0] n_ob;

    logic advance;
    logic out_free;
    logic [7:0] cmin, cmax, rmin, rmax;
    logic [16:0] area;
    logic [7:0] addr, fcol;
    logic [6:0] gsub;
    logic [2:0] bitn;
    logic bad_char;

    assign out_free = !r_ov || !i_stall;
    assign advance = r_in_v && out_free;
    assign o_stall = r_in_v && !out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
        end else if (!o_stall) begin
            r_in_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_op <= i_operation;
            r_fg <= i_fg_color;
            r_bg <= i_bg_color;
            r_xa <= i_x_first;
            r_ya <= i_y_first;
            r_xb <= i_x_second;
            r_yb <= i_y_second;
            r_code <= i_char_code;
        end
    end

    assign cmin = (r_xa <= r_xb) ? r_xa : r_xb;
    assign cmax = (r_xa <= r_xb) ? r_xb : r_xa;
    assign rmin = (r_ya <= r_yb) ? r_ya : r_yb;
    assign rmax = (r_ya <= r_yb) ? r_yb : r_ya;
    assign area = 17'({9'd0, cmax - cmin} + 17'd1) * 17'({9'd0, rmax - rmin} + 17'd1);
    assign gsub = r_code - ldcs_pkg::FIRST_CODE;
    assign bad_char = (r_code < ldcs_pkg::FIRST_CODE) || (32'(gsub) >= GLYPH_COUNT);
    assign addr = r_cl + {5'd0, r_gcol};
    assign bitn = 3'(r_phase - 4'd7);
    assign fcol = ((r_gidx < 7'(ldcs_pkg::FontRows)) && (r_gcol < 3'd5))
        ? ldcs_pkg::font_column(r_gidx, r_gcol) : 8'h00;

    always_comb begin
        n_busy = r_busy; n_aop = r_aop; n_phase = r_phase; n_gcol = r_gcol;
        n_left = r_left; n_hfg = r_hfg; n_hbg = r_hbg; n_cl = r_cl; n_ch = r_ch;
        n_rl = r_rl; n_rh = r_rh; n_gidx = r_gidx;
        n_res = 1'b0; n_od = 1'b0; n_ob = 8'h00; n_ol = 1'b0; n_orj = 1'b0;
        if (r_op != ldcs_pkg::OP_TICK) begin
            if (r_busy || (r_op == ldcs_pkg::OP_CHAR && bad_char)) begin
                n_res = 1'b1;
                n_orj = 1'b1;
            end else begin
                n_busy = 1'b1; n_aop = r_op; n_phase = 4'd0; n_gcol = 3'd0;
                n_hfg = r_fg; n_hbg = r_bg;
                case (r_op)
                    ldcs_pkg::OP_FILL: begin
                        n_cl = cmin; n_ch = cmax; n_rl = rmin; n_rh = rmax; n_left = area;
                    end
                    ldcs_pkg::OP_PIXEL: begin
                        n_cl = r_xa; n_ch = r_xa + 8'd1; n_rl = r_ya; n_rh = r_ya + 8'd1;
                        n_left = 17'd1;
                    end
                    default: begin
                        n_cl = r_xa; n_ch = r_xa; n_rl = r_ya;
                        n_rh = r_ya + 8'(ldcs_pkg::LAST_ROW);
                        n_gidx = gsub; n_left = 17'd0;
                    end
                endcase
            end
        end else if (r_busy) begin
            if (r_aop == ldcs_pkg::OP_TICK) begin
                n_busy = 1'b0;
            end else begin
                n_res = 1'b1;
                n_phase = r_phase + 4'd1;
                case (r_phase)
                    4'd0: n_ob = ldcs_pkg::CMD_COLUMN;
                    4'd1: begin n_od = 1'b1; n_ob = (r_aop == ldcs_pkg::OP_CHAR) ? addr : r_cl; end
                    4'd2: begin n_od = 1'b1; n_ob = (r_aop == ldcs_pkg::OP_CHAR) ? addr : r_ch; end
                    4'd3: n_ob = ldcs_pkg::CMD_PAGE;
                    4'd4: begin n_od = 1'b1; n_ob = r_rl; end
                    4'd5: begin n_od = 1'b1; n_ob = r_rh; end
                    4'd6: n_ob = ldcs_pkg::CMD_WRITE;
                    default: begin
                        n_od = 1'b1;
                        if (r_aop != ldcs_pkg::OP_CHAR) begin
                            n_phase = r_phase;
                            if (r_left != 17'd0) n_left = r_left - 17'd1;
                            n_ob = r_hfg;
                            n_ol = (r_left <= 17'd1);
                            if (n_ol) begin n_busy = 1'b0; n_phase = 4'd0; end
                        end else begin
                            n_ob = fcol[bitn] ? r_hfg : r_hbg;
                            if (bitn == ldcs_pkg::LAST_ROW) begin
                                n_phase = 4'd0;
                                if (r_gcol >= ldcs_pkg::LAST_COLUMN) begin
                                    n_ol = 1'b1; n_busy = 1'b0; n_gcol = 3'd0;
                                end else begin
                                    n_gcol = r_gcol + 3'd1;
                                end
                            end
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0; r_aop <= 2'd0; r_phase <= 4'd0; r_gcol <= 3'd0;
            r_left <= 17'd0; r_hfg <= 8'd0; r_hbg <= 8'd0; r_cl <= 8'd0; r_ch <= 8'd0;
            r_rl <= 8'd0; r_rh <= 8'd0; r_gidx <= 7'd0; r_ov <= 1'b0;
        end else begin
            if (advance) begin
                r_busy <= n_busy; r_aop <= n_aop; r_phase <= n_phase; r_gcol <= n_gcol;
                r_left <= n_left; r_hfg <= n_hfg; r_hbg <= n_hbg; r_cl <= n_cl;
                r_ch <= n_ch; r_rl <= n_rl; r_rh <= n_rh; r_gidx <= n_gidx;
            end
            if (out_free) begin
                r_ov <= advance && n_res;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && n_res) begin
            r_od <= n_od; r_ob <= n_ob; r_ol <= n_ol; r_orj <= n_orj;
        end
    end

    assign o_valid = r_ov;
    assign o_is_data = r_od;
    assign o_word_byte = r_ob;
    assign o_last_word = r_ol;
    assign o_rejected = r_orj;

    a_reject_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && r_orj |-> !r_od && !r_ol && r_ob == 8'h00) else $error("bad reject word");
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && n_res && n_ol |=> !r_busy) else $error("busy after last word");
    a_phase_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && r_aop == ldcs_pkg::OP_CHAR |-> r_phase <= 4'd14 && r_gcol <= 3'd5)
        else $error("glyph phase out of range");
endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for the LCD draw command sequencer, with its own predictor.
`timescale 1ns / 1ps
module testbench;
    localparam int IDLE_LIMIT = 20000;
    localparam int LONG_HOLD = 300;

    typedef struct {
        ldcs_pkg::t_op op;
        logic [7:0] fg, bg, xa, ya, xb, yb;
        logic [6:0] code;
    } t_request;

    typedef struct {
        logic       is_data;
        logic [7:0] word;
        logic       last;
        logic       rejected;
    } t_word;

    localparam logic [7:0] GLYPHS [0:474] = '{
     8'h00,8'h00,8'h00,8'h00,8'h00, 8'h00,8'h06,8'h5F,8'h06,8'h00, 8'h07,8'h03,8'h00,8'h07,8'h03,
     8'h24,8'h7E,8'h24,8'h7E,8'h24, 8'h24,8'h2B,8'h6A,8'h12,8'h00, 8'h63,8'h13,8'h08,8'h64,8'h63,
     8'h36,8'h49,8'h56,8'h20,8'h50, 8'h00,8'h07,8'h03,8'h00,8'h00, 8'h00,8'h3E,8'h41,8'h00,8'h00,
     8'h00,8'h41,8'h3E,8'h00,8'h00, 8'h08,8'h3E,8'h1C,8'h3E,8'h08, 8'h08,8'h08,8'h3E,8'h08,8'h08,
     8'h00,8'hE0,8'h60,8'h00,8'h00, 8'h08,8'h08,8'h08,8'h08,8'h08, 8'h00,8'h60,8'h60,8'h00,8'h00,
     8'h20,8'h10,8'h08,8'h04,8'h02, 8'h3E,8'h51,8'h49,8'h45,8'h3E, 8'h00,8'h42,8'h7F,8'h40,8'h00,
     8'h62,8'h51,8'h49,8'h49,8'h46, 8'h22,8'h49,8'h49,8'h49,8'h36, 8'h18,8'h14,8'h12,8'h7F,8'h10,
     8'h2F,8'h49,8'h49,8'h49,8'h31, 8'h3C,8'h4A,8'h49,8'h49,8'h30, 8'h01,8'h71,8'h09,8'h05,8'h03,
     8'h36,8'h49,8'h49,8'h49,8'h36, 8'h06,8'h49,8'h49,8'h29,8'h1E, 8'h00,8'h6C,8'h6C,8'h00,8'h00,
     8'h00,8'hEC,8'h6C,8'h00,8'h00, 8'h08,8'h14,8'h22,8'h41,8'h00, 8'h24,8'h24,8'h24,8'h24,8'h24,
     8'h00,8'h41,8'h22,8'h14,8'h08, 8'h02,8'h01,8'h59,8'h09,8'h06, 8'h3E,8'h41,8'h5D,8'h55,8'h1E,
     8'h7E,8'h09,8'h09,8'h09,8'h7E, 8'h7F,8'h49,8'h49,8'h49,8'h36, 8'h3E,8'h41,8'h41,8'h41,8'h22,
     8'h7F,8'h41,8'h41,8'h41,8'h3E, 8'h7F,8'h49,8'h49,8'h49,8'h41, 8'h7F,8'h09,8'h09,8'h09,8'h01,
     8'h3E,8'h41,8'h49,8'h49,8'h7A, 8'h7F,8'h08,8'h08,8'h08,8'h7F, 8'h00,8'h41,8'h7F,8'h41,8'h00,
     8'h30,8'h40,8'h40,8'h40,8'h3F, 8'h7F,8'h08,8'h14,8'h22,8'h41, 8'h7F,8'h40,8'h40,8'h40,8'h40,
     8'h7F,8'h02,8'h04,8'h02,8'h7F, 8'h7F,8'h02,8'h04,8'h08,8'h7F, 8'h3E,8'h41,8'h41,8'h41,8'h3E,
     8'h7F,8'h09,8'h09,8'h09,8'h06, 8'h3E,8'h41,8'h51,8'h21,8'h5E, 8'h7F,8'h09,8'h09,8'h19,8'h66,
     8'h26,8'h49,8'h49,8'h49,8'h32, 8'h01,8'h01,8'h7F,8'h01,8'h01, 8'h3F,8'h40,8'h40,8'h40,8'h3F,
     8'h1F,8'h20,8'h40,8'h20,8'h1F, 8'h3F,8'h40,8'h3C,8'h40,8'h3F, 8'h63,8'h14,8'h08,8'h14,8'h63,
     8'h07,8'h08,8'h70,8'h08,8'h07, 8'h71,8'h49,8'h45,8'h43,8'h00, 8'h00,8'h7F,8'h41,8'h41,8'h00,
     8'h02,8'h04,8'h08,8'h10,8'h20, 8'h00,8'h41,8'h41,8'h7F,8'h00, 8'h04,8'h02,8'h01,8'h02,8'h04,
     8'h80,8'h80,8'h80,8'h80,8'h80, 8'h20,8'h40,8'h80,8'h40,8'h20, 8'h20,8'h54,8'h54,8'h54,8'h78,
     8'h7F,8'h44,8'h44,8'h44,8'h38, 8'h38,8'h44,8'h44,8'h44,8'h28, 8'h38,8'h44,8'h44,8'h44,8'h7F,
     8'h38,8'h54,8'h54,8'h54,8'h18, 8'h08,8'h7E,8'h09,8'h09,8'h00, 8'h18,8'hA4,8'hA4,8'hA4,8'h7C,
     8'h7F,8'h04,8'h04,8'h78,8'h00, 8'h00,8'h00,8'h7D,8'h00,8'h00, 8'h40,8'h80,8'h84,8'h7D,8'h00,
     8'h7F,8'h10,8'h28,8'h44,8'h00, 8'h00,8'h00,8'h7F,8'h40,8'h00, 8'h7C,8'h04,8'h18,8'h04,8'h78,
     8'h7C,8'h04,8'h04,8'h78,8'h00, 8'h38,8'h44,8'h44,8'h44,8'h38, 8'hFC,8'h44,8'h44,8'h44,8'h38,
     8'h38,8'h44,8'h44,8'h44,8'hFC, 8'h44,8'h78,8'h44,8'h04,8'h08, 8'h08,8'h54,8'h54,8'h54,8'h20,
     8'h04,8'h3E,8'h44,8'h24,8'h00, 8'h3C,8'h40,8'h20,8'h7C,8'h00, 8'h1C,8'h20,8'h40,8'h20,8'h1C,
     8'h3C,8'h60,8'h30,8'h60,8'h3C, 8'h6C,8'h10,8'h10,8'h6C,8'h00, 8'h9C,8'hA0,8'h60,8'h3C,8'h00,
     8'h64,8'h54,8'h54,8'h4C,8'h00, 8'h33,8'h66,8'hCC,8'h66,8'h33, 8'h00,8'h00,8'h7F,8'h00,8'h00,
     8'hCC,8'h66,8'h33,8'h66,8'hCC, 8'h02,8'h01,8'h02,8'h01,8'h00
    };

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic       o_stall;
    logic [1:0] i_operation = ldcs_pkg::OP_TICK;
    logic [7:0] i_fg_color = '0, i_bg_color = '0;
    logic [7:0] i_x_first = '0, i_y_first = '0, i_x_second = '0, i_y_second = '0;
    logic [6:0] i_char_code = '0;
    logic       o_valid;
    logic       i_stall = 1'b0;
    logic       o_is_data;
    logic [7:0] o_word_byte;
    logic       o_last_word;
    logic       o_rejected;

    lcd_draw_command_sequencer dut (.*);

    t_request pending_q[$];
    t_word    words_q[$];
    int       error_count = 0;
    int       words_seen = 0;
    int       requests_sent = 0;
    int       sender_gap = 0;
    int       receiver_hold = 0;
    bit       long_hold_done = 0;
    int       idle_cycles = 0;

    // Predictor state.
    bit            s_busy;
    ldcs_pkg::t_op s_op;
    int            s_phase;
    int            s_column;
    int            s_left;
    logic [7:0]    s_fg, s_bg, s_col_lo, s_col_hi, s_row_lo, s_row_hi;
    logic [6:0]    s_glyph;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    task automatic report(input string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        error_count++;
    endtask

    task automatic push_word(input logic d, input logic [7:0] b, input logic l,
                             input logic r);
        t_word w;
        w.is_data = d;
        w.word = b;
        w.last = l;
        w.rejected = r;
        words_q.push_back(w);
    endtask

    task automatic predict_words(input t_request rq);
        logic [7:0] addr;
        logic [7:0] bits;
        int         bit_idx;
        bit         fin;
        if (rq.op != ldcs_pkg::OP_TICK) begin
            if (s_busy || (rq.op == ldcs_pkg::OP_CHAR && (rq.code < 32 || rq.code > 126))) begin
                push_word(0, 8'h00, 0, 1);
                return;
            end
            s_busy = 1;
            s_op = rq.op;
            s_phase = 0;
            s_column = 0;
            s_fg = rq.fg;
            s_bg = rq.bg;
            if (rq.op == ldcs_pkg::OP_FILL) begin
                s_col_lo = (rq.xa <= rq.xb) ? rq.xa : rq.xb;
                s_col_hi = (rq.xa <= rq.xb) ? rq.xb : rq.xa;
                s_row_lo = (rq.ya <= rq.yb) ? rq.ya : rq.yb;
                s_row_hi = (rq.ya <= rq.yb) ? rq.yb : rq.ya;
                s_left = (int'(s_col_hi) - int'(s_col_lo) + 1)
                       * (int'(s_row_hi) - int'(s_row_lo) + 1);
            end else if (rq.op == ldcs_pkg::OP_PIXEL) begin
                s_col_lo = rq.xa;
                s_col_hi = rq.xa + 8'd1;
                s_row_lo = rq.ya;
                s_row_hi = rq.ya + 8'd1;
                s_left = 1;
            end else begin
                s_col_lo = rq.xa;
                s_col_hi = rq.xa;
                s_row_lo = rq.ya;
                s_row_hi = rq.ya + 8'd7;
                s_glyph = rq.code - 7'd32;
                s_left = 0;
            end
            return;
        end
        if (!s_busy) return;
        addr = (s_op == ldcs_pkg::OP_CHAR) ? s_col_lo + 8'(s_column) : 8'h00;
        case (s_phase)
            0: push_word(0, ldcs_pkg::CMD_COLUMN, 0, 0);
            1: push_word(1, (s_op == ldcs_pkg::OP_CHAR) ? addr : s_col_lo, 0, 0);
            2: push_word(1, (s_op == ldcs_pkg::OP_CHAR) ? addr : s_col_hi, 0, 0);
            3: push_word(0, ldcs_pkg::CMD_PAGE, 0, 0);
            4: push_word(1, s_row_lo, 0, 0);
            5: push_word(1, s_row_hi, 0, 0);
            6: push_word(0, ldcs_pkg::CMD_WRITE, 0, 0);
            default: begin
                if (s_op != ldcs_pkg::OP_CHAR) begin
                    if (s_left > 0) s_left--;
                    fin = (s_left == 0);
                    push_word(1, s_fg, fin, 0);
                    if (fin) begin
                        s_busy = 0;
                        s_phase = 0;
                    end
                end else begin
                    bit_idx = s_phase - 7;
                    bits = (s_column < 5) ? GLYPHS[int'(s_glyph) * 5 + s_column] : 8'h00;
                    fin = (bit_idx == 7) && (s_column >= 5);
                    push_word(1, bits[bit_idx] ? s_fg : s_bg, fin, 0);
                    if (fin) begin
                        s_busy = 0;
                        s_phase = 0;
                        s_column = 0;
                    end else if (bit_idx == 7) begin
                        s_column++;
                        s_phase = 0;
                    end else begin
                        s_phase++;
                    end
                end
                return;
            end
        endcase
        s_phase++;
    endtask

    task automatic add_request(input ldcs_pkg::t_op op, input logic [7:0] xa,
                               input logic [7:0] ya,
                               input logic [7:0] xb, input logic [7:0] yb,
                               input logic [6:0] code);
        t_request rq;
        rq.op = op;
        rq.fg = 8'($urandom);
        rq.bg = 8'($urandom);
        rq.xa = xa;
        rq.ya = ya;
        rq.xb = xb;
        rq.yb = yb;
        rq.code = code;
        pending_q.push_back(rq);
        requests_sent++;
    endtask

    task automatic add_ticks(input int n);
        for (int k = 0; k < n; k++) begin
            add_request(ldcs_pkg::OP_TICK, 8'($urandom), 8'($urandom), 8'($urandom),
                        8'($urandom), 7'($urandom));
        end
    endtask

    task automatic drain();
        while (!(pending_q.size() == 0 && !i_valid && words_q.size() == 0))
            @(negedge i_clk);
    endtask

    // Driver.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                predict_words('{ldcs_pkg::t_op'(i_operation), i_fg_color, i_bg_color,
                                i_x_first, i_y_first, i_x_second, i_y_second,
                                i_char_code});
            end
            if (!i_valid || !o_stall) begin
                if (sender_gap > 0 || pending_q.size() == 0) begin
                    if (sender_gap > 0) sender_gap <= sender_gap - 1;
                    i_valid <= 1'b0;
                end else begin
                    t_request rq;
                    rq = pending_q.pop_front();
                    i_valid <= 1'b1;
                    i_operation <= rq.op;
                    i_fg_color <= rq.fg;
                    i_bg_color <= rq.bg;
                    i_x_first <= rq.xa;
                    i_y_first <= rq.ya;
                    i_x_second <= rq.xb;
                    i_y_second <= rq.yb;
                    i_char_code <= rq.code;
                    if (($urandom_range(0, 999) / 100) % 4 == 0 && $urandom_range(0, 3) == 0)
                        sender_gap <= ($urandom_range(0, 19) == 0) ? $urandom_range(10, 60)
                                                                   : $urandom_range(1, 3);
                end
            end
        end
    end

    // Monitor and checker.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                words_seen++;
                if (words_q.size() == 0) begin
                    report($sformatf("unexpected word %h", o_word_byte));
                end else begin
                    t_word w;
                    w = words_q.pop_front();
                    if (o_is_data !== w.is_data)
                        report($sformatf("is_data %b, want %b", o_is_data, w.is_data));
                    if (o_word_byte !== w.word)
                        report($sformatf("word_byte %h, want %h", o_word_byte, w.word));
                    if (o_last_word !== w.last)
                        report($sformatf("last_word %b, want %b", o_last_word, w.last));
                    if (o_rejected !== w.rejected)
                        report($sformatf("rejected %b, want %b", o_rejected, w.rejected));
                end
            end
            if (receiver_hold > 0) begin
                receiver_hold <= receiver_hold - 1;
                i_stall <= 1'b1;
            end else if (!long_hold_done && words_seen >= 300) begin
                long_hold_done <= 1'b1;
                receiver_hold <= LONG_HOLD;
                i_stall <= 1'b1;
            end else if ((words_seen / 300) % 3 == 0) begin
                i_stall <= 1'b0;
            end else if ($urandom_range(0, 9) == 0) begin
                receiver_hold <= ($urandom_range(0, 15) == 0) ? $urandom_range(10, 50)
                                                              : $urandom_range(0, 2);
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || !i_rst_n) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Watchdog expired with %0d words outstanding", words_q.size());
            $display("Test completed with failures");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int   op_pick, dx, dy;
        logic [7:0] xa, ya;
        s_busy = 0;
        s_op = ldcs_pkg::OP_TICK;
        s_phase = 0;
        s_column = 0;
        s_left = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        add_ticks(2);
        add_request(ldcs_pkg::OP_PIXEL, 8'd255, 8'd255, 8'd0, 8'd0, 7'd0);
        add_ticks(8);
        add_request(ldcs_pkg::OP_FILL, 8'd9, 8'd7, 8'd5, 8'd3, 7'd0);
        add_request(ldcs_pkg::OP_CHAR, 8'd1, 8'd1, 8'd0, 8'd0, 7'd65);
        add_ticks(7 + 25);
        add_request(ldcs_pkg::OP_FILL, 8'd40, 8'd40, 8'd40, 8'd40, 7'd0);
        add_ticks(8);
        add_request(ldcs_pkg::OP_CHAR, 8'd252, 8'd250, 8'd0, 8'd0, 7'd32);
        add_ticks(90);
        add_request(ldcs_pkg::OP_CHAR, 8'd0, 8'd0, 8'd255, 8'd255, 7'd126);
        add_ticks(90);
        add_request(ldcs_pkg::OP_CHAR, 8'd10, 8'd10, 8'd0, 8'd0, 7'd31);
        add_request(ldcs_pkg::OP_CHAR, 8'd10, 8'd10, 8'd0, 8'd0, 7'd127);
        add_request(ldcs_pkg::OP_CHAR, 8'd10, 8'd10, 8'd0, 8'd0, 7'd0);
        add_request(ldcs_pkg::OP_FILL, 8'd255, 8'd9, 8'd0, 8'd9, 7'd0);
        add_request(ldcs_pkg::OP_PIXEL, 8'd3, 8'd3, 8'd0, 8'd0, 7'd33);
        add_ticks(7 + 256);
        drain();

        for (int phase_idx = 0; phase_idx < 3; phase_idx++) begin
            while (requests_sent < 500 + 140 * (phase_idx + 1)) begin
                op_pick = $urandom_range(0, 9);
                xa = 8'($urandom);
                ya = 8'($urandom);
                dx = $urandom_range(0, 7);
                dy = $urandom_range(0, 7);
                if (op_pick < 4) begin
                    if ($urandom_range(0, 1))
                        add_request(ldcs_pkg::OP_FILL, xa, ya, xa + 8'(dx), ya + 8'(dy),
                                    7'($urandom));
                    else
                        add_request(ldcs_pkg::OP_FILL, xa + 8'(dx), ya + 8'(dy), xa, ya,
                                    7'($urandom));
                    add_ticks(7 + (dx + 1) * (dy + 1) - $urandom_range(0, 1) * 2);
                end else if (op_pick < 6) begin
                    add_request(ldcs_pkg::OP_PIXEL, xa, ya, 8'($urandom), 8'($urandom),
                                7'($urandom));
                    add_ticks(8);
                end else if (op_pick < 8) begin
                    add_request(ldcs_pkg::OP_CHAR, xa, ya, 8'($urandom), 8'($urandom),
                                7'($urandom_range(32, 126)));
                    add_ticks($urandom_range(0, 3) == 0 ? $urandom_range(20, 89) : 90);
                end else if (op_pick == 8) begin
                    add_request(ldcs_pkg::OP_CHAR, xa, ya, 8'($urandom), 8'($urandom),
                                $urandom_range(0, 1) ? 7'($urandom_range(0, 31)) : 7'd127);
                    add_ticks($urandom_range(0, 2));
                end else begin
                    add_request(ldcs_pkg::t_op'($urandom_range(1, 3)), xa, ya, 8'($urandom),
                                8'($urandom), 7'($urandom));
                    add_ticks($urandom_range(0, 3));
                end
            end
            add_ticks(10);
            drain();
        end

        repeat (10) @(posedge i_clk);
        $display("Covered fills with a 256-pixel row, pixels, glyphs with address wrap,");
        $display("rejections and idle ticks: %0d requests, %0d words", requests_sent,
                 words_seen);
        if (error_count == 0 && words_q.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
